>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle
`define ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// condition is followed by a property in the next cycle
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

>>> design/rcc_pkg.sv
`default_nettype none
package rcc_pkg;

   localparam int LANES     = 3;
   localparam int DIV_CELLS = 8;

   localparam logic [7:0]  FULL_LEVEL = 8'd255;
   localparam logic [7:0]  BLACK_CAP  = 8'd254;
   localparam logic [15:0] CEIL_BIAS  = 16'd254;

   localparam logic KIND_FWD = 1'b0;
   localparam logic KIND_REV = 1'b1;

   // one word in flight through the divider chain
   typedef struct packed {
      logic                       valid;
      logic                       kind;
      logic [7:0]                 black;
      logic [7:0]                 div;
      logic [LANES-1:0][7:0]      rem;
      logic [LANES-1:0][7:0]      quo;
   } stage_type;

endpackage
`default_nettype wire

>>> design/rcc_front.sv
`default_nettype none
`include "assert_macros.svh"
module rcc_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              take,
   input  wire logic              kind,
   input  wire logic [7:0]        chan_one,
   input  wire logic [7:0]        chan_two,
   input  wire logic [7:0]        chan_three,
   input  wire logic [7:0]        black_in,
   output rcc_pkg::stage_type     next_word
);

   rcc_pkg::stage_type prep_ff;
   rcc_pkg::stage_type prep_in;

   logic [rcc_pkg::LANES-1:0][7:0] chan;

   assign chan[0] = chan_one;
   assign chan[1] = chan_two;
   assign chan[2] = chan_three;

   always_comb begin : prep
      logic [7:0]  least;
      logic [7:0]  kf;
      logic [7:0]  lvl;
      logic [7:0]  rev_div;
      logic [15:0] num;
      least = ~chan[0];
      if (~chan[1] < least) begin
         least = ~chan[1];
      end
      if (~chan[2] < least) begin
         least = ~chan[2];
      end
      kf      = (least > rcc_pkg::BLACK_CAP) ? rcc_pkg::BLACK_CAP : least;
      rev_div = ~black_in;
      prep_in       = '0;
      prep_in.valid = take;
      prep_in.kind  = kind;
      if (kind == rcc_pkg::KIND_FWD) begin
         prep_in.black = kf;
         prep_in.div   = ~kf;
      end else begin
         prep_in.black = black_in;
         prep_in.div   = rcc_pkg::FULL_LEVEL;
      end
      for (int i = 0; i < rcc_pkg::LANES; i++) begin
         lvl = ~chan[i] - kf;
         if (kind == rcc_pkg::KIND_FWD) begin
            num = {lvl, 8'd0} - {8'd0, lvl};
         end else begin
            num = ({8'd0, chan[i]} * {8'd0, rev_div}) + rcc_pkg::CEIL_BIAS;
         end
         prep_in.rem[i] = num[15:8];
         prep_in.quo[i] = num[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff.valid <= 1'b0;
      end else begin
         prep_ff <= prep_in;
      end
   end

   assign next_word = prep_ff;

   `ASSERT_SAME(fwd_black_capped, clock, reset,
      prep_ff.valid && prep_ff.kind == rcc_pkg::KIND_FWD, prep_ff.black <= rcc_pkg::BLACK_CAP)
   `ASSERT_SAME(rev_div_full, clock, reset,
      prep_ff.valid && prep_ff.kind == rcc_pkg::KIND_REV, prep_ff.div == rcc_pkg::FULL_LEVEL)

endmodule
`default_nettype wire

>>> design/rcc_div_cell.sv
`default_nettype none
`include "assert_macros.svh"
module rcc_div_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rcc_pkg::stage_type prev_word,
   output rcc_pkg::stage_type     next_word
);

   rcc_pkg::stage_type stage_ff;
   rcc_pkg::stage_type stage_in;

   // one restoring step per lane: bring down a bit, try the subtract
   always_comb begin : step
      logic [8:0] trial;
      logic [8:0] diff;
      logic       fits;
      stage_in = prev_word;
      for (int i = 0; i < rcc_pkg::LANES; i++) begin
         trial = {prev_word.rem[i], prev_word.quo[i][7]};
         diff  = trial - {1'b0, prev_word.div};
         fits  = (trial >= {1'b0, prev_word.div});
         stage_in.rem[i] = fits ? diff[7:0] : trial[7:0];
         stage_in.quo[i] = {prev_word.quo[i][6:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign next_word = stage_ff;

   `ASSERT_NEXT(valid_moves_on, clock, reset, prev_word.valid, stage_ff.valid)
   `ASSERT_SAME(rem_below_div, clock, reset, stage_ff.valid,
      stage_ff.rem[0] < stage_ff.div && stage_ff.rem[1] < stage_ff.div &&
      stage_ff.rem[2] < stage_ff.div)

endmodule
`default_nettype wire

>>> design/rgb_cmyk_color_convert.sv
// channel    | ports                                   | handshake
// request    | req_kind, req_chan_*, req_black_in      | start while busy is low
// response   | rsp_out_*, rsp_black_out                | rsp_valid, one cycle
//
// one word accepted every cycle; busy is always low
// each result passes through one prep stage, eight
// divider cells (one quotient bit each) and the output register
// reset clears the valid bits of all stages; words in flight are dropped
// the receiver cannot stall, results are shown for exactly one cycle
`default_nettype none
`include "assert_macros.svh"
module rgb_cmyk_color_convert (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic       req_kind,
   input  wire logic [7:0] req_chan_one,
   input  wire logic [7:0] req_chan_two,
   input  wire logic [7:0] req_chan_three,
   input  wire logic [7:0] req_black_in,
   output logic            rsp_valid,
   output logic [7:0]      rsp_out_one,
   output logic [7:0]      rsp_out_two,
   output logic [7:0]      rsp_out_three,
   output logic [7:0]      rsp_black_out
);

   rcc_pkg::stage_type chain [rcc_pkg::DIV_CELLS+1];

   logic                            valid_ff;
   logic [rcc_pkg::LANES-1:0][7:0]  out_ff;
   logic [rcc_pkg::LANES-1:0][7:0]  out_in;
   logic [7:0]                      black_ff;
   logic [7:0]                      black_in;

   assign busy = 1'b0;

   rcc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .take       (start & ~busy),
      .kind       (req_kind),
      .chan_one   (req_chan_one),
      .chan_two   (req_chan_two),
      .chan_three (req_chan_three),
      .black_in   (req_black_in),
      .next_word  (chain[0])
   );

   for (genvar g = 0; g < rcc_pkg::DIV_CELLS; g++) begin : g_cell
      rcc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .prev_word (chain[g]),
         .next_word (chain[g+1])
      );
   end

   always_comb begin
      for (int i = 0; i < rcc_pkg::LANES; i++) begin
         if (chain[rcc_pkg::DIV_CELLS].kind == rcc_pkg::KIND_FWD) begin
            out_in[i] = chain[rcc_pkg::DIV_CELLS].quo[i];
         end else begin
            out_in[i] = ~chain[rcc_pkg::DIV_CELLS].black - chain[rcc_pkg::DIV_CELLS].quo[i];
         end
      end
      black_in = (chain[rcc_pkg::DIV_CELLS].kind == rcc_pkg::KIND_FWD) ?
                 chain[rcc_pkg::DIV_CELLS].black : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= chain[rcc_pkg::DIV_CELLS].valid;
      end
   end

   always_ff @(posedge clock) begin
      out_ff   <= out_in;
      black_ff <= black_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_one   = out_ff[0];
   assign rsp_out_two   = out_ff[1];
   assign rsp_out_three = out_ff[2];
   assign rsp_black_out = black_ff;

   `ASSERT_SAME(black_out_range, clock, reset, rsp_valid, rsp_black_out <= rcc_pkg::BLACK_CAP)
   `ASSERT_NEXT(last_cell_to_output, clock, reset, chain[rcc_pkg::DIV_CELLS].valid, rsp_valid)

endmodule
`default_nettype wire

>>> sim/tb_rgb_cmyk_color_convert.sv
`timescale 1ns / 100ps

typedef struct packed {
   logic [7:0] one;
   logic [7:0] two;
   logic [7:0] three;
   logic [7:0] black;
} pixel_out_type;

class pixel_checker;
   pixel_out_type expected_pixels[$];
   int            mismatches;

   function new();
      mismatches = 0;
   endfunction

   // forward lane: floor((255 - ch - k) * 255 / (255 - k))
   function logic [7:0] cmyk_lane(int unsigned ch, int unsigned k);
      return 8'(((255 - ch - k) * 255) / (255 - k));
   endfunction

   // reverse lane: 255 - k - ceil(col * (255 - k) / 255)
   function logic [7:0] rgb_lane(int unsigned col, int unsigned k);
      int unsigned up;
      up = (col * (255 - k) + 254) / 255;
      return 8'(255 - k - up);
   endfunction

   function pixel_out_type convert_pixel(logic kind, logic [7:0] c1, logic [7:0] c2,
                                         logic [7:0] c3, logic [7:0] kb);
      pixel_out_type px;
      int unsigned   k;
      if (kind == rcc_pkg::KIND_FWD) begin
         k = 255 - c1;
         if (255 - c2 < k) k = 255 - c2;
         if (255 - c3 < k) k = 255 - c3;
         if (k > 254) k = 254;
         px.one   = cmyk_lane(32'(c1), k);
         px.two   = cmyk_lane(32'(c2), k);
         px.three = cmyk_lane(32'(c3), k);
         px.black = 8'(k);
      end else begin
         px.one   = rgb_lane(32'(c1), 32'(kb));
         px.two   = rgb_lane(32'(c2), 32'(kb));
         px.three = rgb_lane(32'(c3), 32'(kb));
         px.black = 8'd0;
      end
      return px;
   endfunction

   function void note_word(logic kind, logic [7:0] c1, logic [7:0] c2,
                           logic [7:0] c3, logic [7:0] kb);
      expected_pixels.push_back(convert_pixel(kind, c1, c2, c3, kb));
   endfunction

   function void check_word(pixel_out_type got);
      pixel_out_type want;
      if (expected_pixels.size() == 0) begin
         $error("unexpected result word %h", got);
         mismatches++;
         return;
      end
      want = expected_pixels.pop_front();
      if (got.one !== want.one) begin
         $error("out_one expected %0d actual %0d", want.one, got.one);
         mismatches++;
      end
      if (got.two !== want.two) begin
         $error("out_two expected %0d actual %0d", want.two, got.two);
         mismatches++;
      end
      if (got.three !== want.three) begin
         $error("out_three expected %0d actual %0d", want.three, got.three);
         mismatches++;
      end
      if (got.black !== want.black) begin
         $error("black_out expected %0d actual %0d", want.black, got.black);
         mismatches++;
      end
   endfunction
endclass

module tb_rgb_cmyk_color_convert;

   localparam int RANDOM_WORDS = 750;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 14;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       req_kind = 1'b0;
   logic [7:0] req_chan_one = 8'd0;
   logic [7:0] req_chan_two = 8'd0;
   logic [7:0] req_chan_three = 8'd0;
   logic [7:0] req_black_in = 8'd0;
   wire logic       busy;
   wire logic       rsp_valid;
   wire logic [7:0] rsp_out_one;
   wire logic [7:0] rsp_out_two;
   wire logic [7:0] rsp_out_three;
   wire logic [7:0] rsp_black_out;

   pixel_checker checker_h = new();
   int           cycle_count = 0;

   rgb_cmyk_color_convert uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_chan_one   (req_chan_one),
      .req_chan_two   (req_chan_two),
      .req_chan_three (req_chan_three),
      .req_black_in   (req_black_in),
      .rsp_valid      (rsp_valid),
      .rsp_out_one    (rsp_out_one),
      .rsp_out_two    (rsp_out_two),
      .rsp_out_three  (rsp_out_three),
      .rsp_black_out  (rsp_black_out)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            checker_h.note_word(req_kind, req_chan_one, req_chan_two, req_chan_three,
                                req_black_in);
         end
         if (rsp_valid) begin
            checker_h.check_word({rsp_out_one, rsp_out_two, rsp_out_three, rsp_black_out});
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   // holds the word until it is taken
   task automatic send_pixel(logic kind, logic [7:0] c1, logic [7:0] c2, logic [7:0] c3,
                             logic [7:0] kb);
      req_kind       <= kind;
      req_chan_one   <= c1;
      req_chan_two   <= c2;
      req_chan_three <= c3;
      req_black_in   <= kb;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // idle with noise on the word ports
   task automatic idle_cycles(int n);
      repeat (n) begin
         start          <= 1'b0;
         req_kind       <= 1'($urandom_range(0, 1));
         req_chan_one   <= 8'($urandom_range(0, 255));
         req_chan_two   <= 8'($urandom_range(0, 255));
         req_chan_three <= 8'($urandom_range(0, 255));
         req_black_in   <= 8'($urandom_range(0, 255));
         @(posedge clock);
      end
   endtask

   function automatic logic [7:0] pick_level(bit edgy);
      if (!edgy) return 8'($urandom_range(0, 255));
      case ($urandom_range(0, 4))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'd254;
         3: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      int  sent;
      int  burst;
      bit  edgy;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // rgb to cmyk corners
      send_pixel(rcc_pkg::KIND_FWD, 8'd0,   8'd0,   8'd0,   8'd0);
      send_pixel(rcc_pkg::KIND_FWD, 8'd255, 8'd255, 8'd255, 8'd0);
      send_pixel(rcc_pkg::KIND_FWD, 8'd255, 8'd0,   8'd0,   8'd0);
      send_pixel(rcc_pkg::KIND_FWD, 8'd0,   8'd255, 8'd0,   8'd255);
      send_pixel(rcc_pkg::KIND_FWD, 8'd0,   8'd0,   8'd255, 8'd0);
      send_pixel(rcc_pkg::KIND_FWD, 8'd1,   8'd1,   8'd1,   8'd0);
      send_pixel(rcc_pkg::KIND_FWD, 8'd0,   8'd0,   8'd1,   8'd0);
      send_pixel(rcc_pkg::KIND_FWD, 8'd254, 8'd254, 8'd254, 8'd128);
      send_pixel(rcc_pkg::KIND_FWD, 8'd128, 8'd64,  8'd200, 8'd255);
      send_pixel(rcc_pkg::KIND_FWD, 8'd170, 8'd85,  8'd255, 8'd85);
      idle_cycles(3);
      // cmyk to rgb corners
      send_pixel(rcc_pkg::KIND_REV, 8'd0,   8'd0,   8'd0,   8'd0);
      send_pixel(rcc_pkg::KIND_REV, 8'd255, 8'd255, 8'd255, 8'd0);
      send_pixel(rcc_pkg::KIND_REV, 8'd255, 8'd255, 8'd255, 8'd255);
      send_pixel(rcc_pkg::KIND_REV, 8'd0,   8'd0,   8'd0,   8'd255);
      send_pixel(rcc_pkg::KIND_REV, 8'd0,   8'd0,   8'd0,   8'd254);
      send_pixel(rcc_pkg::KIND_REV, 8'd255, 8'd128, 8'd1,   8'd254);
      send_pixel(rcc_pkg::KIND_REV, 8'd1,   8'd1,   8'd1,   8'd0);
      send_pixel(rcc_pkg::KIND_REV, 8'd128, 8'd64,  8'd32,  8'd100);
      send_pixel(rcc_pkg::KIND_REV, 8'd255, 8'd0,   8'd254, 8'd1);
      send_pixel(rcc_pkg::KIND_REV, 8'd170, 8'd85,  8'd127, 8'd170);
      idle_cycles(12);

      sent = 0;
      while (sent < RANDOM_WORDS) begin
         burst = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 12);
         repeat (burst) begin
            edgy = ($urandom_range(0, 4) == 0);
            send_pixel(1'($urandom_range(0, 1)), pick_level(edgy), pick_level(edgy),
                       pick_level(edgy), pick_level(edgy));
            sent++;
         end
         idle_cycles($urandom_range(1, 11));
      end

      idle_cycles(1);
      while (checker_h.expected_pixels.size() != 0) @(posedge clock);
      idle_cycles(DRAIN_CYCLES);

      if (checker_h.mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
